// ===== rtl/core/mobius_pixel_remap_address_unit_assert.svh =====
// Assertion macros for the Mobius remap address unit.
// Expects clk_i and rst_ni in the including module's scope.
`ifndef MOBIUS_PIXEL_REMAP_ADDRESS_UNIT_ASSERT_SVH
`define MOBIUS_PIXEL_REMAP_ADDRESS_UNIT_ASSERT_SVH
`ifndef SYNTH
`define MPRA_ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("mobius remap: assertion failed");
`define MPRA_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("mobius remap: reset assertion failed");
`else
`define MPRA_ASSERT_CLK(lbl, prop)
`define MPRA_ASSERT_RST(lbl, prop)
`endif
`endif

// ===== rtl/core/mpra_pkg.sv =====
// Shared types, constants and helpers for the Mobius remap address unit.
// No dependencies.
package mpra_pkg;

  localparam int COEF_W    = 32;  // one Q-format coefficient half
  localparam int SPLIT_W   = 24;  // low slice width for wide multiplies
  localparam int QUOT_BITS = 31;  // quotient magnitude bits
  localparam int SUM_W     = 33;  // signed offset sum
  localparam int VAL_W     = 32;  // magnitude of offset sum
  localparam int MOD_W     = 13;  // modulus register width
  localparam int ADDR_W    = 12;  // address width
  localparam int STEP_BITS = 2;   // dividend bits per remainder stage
  localparam int CFG_IDX_W = 3;

  localparam logic [QUOT_BITS-1:0] QUOT_MAX    = '1;
  localparam logic [SUM_W-1:0]     ADDR_OFFSET = 33'd1000000;
  localparam logic [MOD_W-1:0]     MOD_MAX     = 13'd4096;
  localparam logic [MOD_W-1:0]     MOD_MIN     = 13'd1;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_DEN_ZERO = 2'd1,
    STATUS_SAT      = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COEF_A  = 3'd0,
    CFG_COEF_B  = 3'd1,
    CFG_COEF_C  = 3'd2,
    CFG_COEF_D  = 3'd3,
    CFG_FRAME_W = 3'd4,
    CFG_FRAME_H = 3'd5
  } cfg_idx_e;

  // control that rides along the back half of the pipeline
  typedef struct packed {
    logic valid;
    logic den_zero;
    logic sat_re;
    logic sat_im;
    logic neg_re;
    logic neg_im;
  } ctl_t;

  // one restoring remainder step: shift in one dividend bit, subtract if fits
  function automatic logic [ADDR_W-1:0] rem_step(input logic [ADDR_W-1:0] r,
                                                input logic b,
                                                input logic [MOD_W-1:0] m);
    logic [MOD_W-1:0] t;
    t = {r, b};
    if (t >= m) begin
      t = t - m;
    end
    return t[ADDR_W-1:0];
  endfunction

endpackage

// ===== rtl/core/mpra_front.sv =====
// Linear front end: numerator a - b*z and denominator c + d*z.
// Two register stages. Depends on mpra_pkg.
module mpra_front #(
  parameter int CoordW = 12
) (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic signed [CoordW-1:0]            zr_i,
  input  logic signed [CoordW-1:0]            zi_i,
  input  logic signed [mpra_pkg::COEF_W-1:0]  ar_i,
  input  logic signed [mpra_pkg::COEF_W-1:0]  ai_i,
  input  logic signed [mpra_pkg::COEF_W-1:0]  br_i,
  input  logic signed [mpra_pkg::COEF_W-1:0]  bi_i,
  input  logic signed [mpra_pkg::COEF_W-1:0]  cr_i,
  input  logic signed [mpra_pkg::COEF_W-1:0]  ci_i,
  input  logic signed [mpra_pkg::COEF_W-1:0]  dr_i,
  input  logic signed [mpra_pkg::COEF_W-1:0]  di_i,
  output logic signed [mpra_pkg::COEF_W+CoordW+1:0] nr_o,
  output logic signed [mpra_pkg::COEF_W+CoordW+1:0] ni_o,
  output logic signed [mpra_pkg::COEF_W+CoordW+1:0] er_o,
  output logic signed [mpra_pkg::COEF_W+CoordW+1:0] ei_o
);

  localparam int PrW = mpra_pkg::COEF_W + CoordW;
  localparam int EW  = PrW + 2;

  logic signed [PrW-1:0] brzr_d, bizi_d, brzi_d, bizr_d;
  logic signed [PrW-1:0] drzr_d, dizi_d, drzi_d, dizr_d;
  logic signed [PrW-1:0] brzr_q, bizi_q, brzi_q, bizr_q;
  logic signed [PrW-1:0] drzr_q, dizi_q, drzi_q, dizr_q;
  logic signed [EW-1:0]  nr_d, ni_d, er_d, ei_d;
  logic signed [EW-1:0]  nr_q, ni_q, er_q, ei_q;

  assign brzr_d = br_i * zr_i;
  assign bizi_d = bi_i * zi_i;
  assign brzi_d = br_i * zi_i;
  assign bizr_d = bi_i * zr_i;
  assign drzr_d = dr_i * zr_i;
  assign dizi_d = di_i * zi_i;
  assign drzi_d = dr_i * zi_i;
  assign dizr_d = di_i * zr_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      brzr_q <= brzr_d;
      bizi_q <= bizi_d;
      brzi_q <= brzi_d;
      bizr_q <= bizr_d;
      drzr_q <= drzr_d;
      dizi_q <= dizi_d;
      drzi_q <= drzi_d;
      dizr_q <= dizr_d;
    end
  end

  assign nr_d = EW'(ar_i) - EW'(brzr_q) + EW'(bizi_q);
  assign ni_d = EW'(ai_i) - EW'(brzi_q) - EW'(bizr_q);
  assign er_d = EW'(cr_i) + EW'(drzr_q) - EW'(dizi_q);
  assign ei_d = EW'(ci_i) + EW'(drzi_q) + EW'(dizr_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nr_q <= nr_d;
      ni_q <= ni_d;
      er_q <= er_d;
      ei_q <= ei_d;
    end
  end

  assign nr_o = nr_q;
  assign ni_o = ni_q;
  assign er_o = er_q;
  assign ei_o = ei_q;

endmodule

// ===== rtl/core/mpra_wmul.sv =====
// Wide signed multiplier split into four partial products, two stages.
// Depends on mpra_pkg.
module mpra_wmul #(
  parameter int W = 46
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic signed [W-1:0]   a_i,
  input  logic signed [W-1:0]   b_i,
  output logic signed [2*W-1:0] p_o
);

  localparam int LoW = mpra_pkg::SPLIT_W;
  localparam int HiW = W - LoW;
  localparam int PW  = 2 * W;

  logic [LoW-1:0]          a_lo, b_lo;
  logic signed [HiW-1:0]   a_hi, b_hi;
  logic [2*LoW-1:0]        ll_d, ll_q;
  logic signed [LoW+HiW:0] lh_d, hl_d, lh_q, hl_q;
  logic signed [2*HiW-1:0] hh_d, hh_q;
  logic signed [PW-1:0]    p_d, p_q;

  assign a_lo = a_i[LoW-1:0];
  assign b_lo = b_i[LoW-1:0];
  assign a_hi = a_i[W-1:LoW];
  assign b_hi = b_i[W-1:LoW];

  assign ll_d = a_lo * b_lo;
  assign lh_d = $signed({1'b0, a_lo}) * b_hi;
  assign hl_d = a_hi * $signed({1'b0, b_lo});
  assign hh_d = a_hi * b_hi;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ll_q <= ll_d;
      lh_q <= lh_d;
      hl_q <= hl_d;
      hh_q <= hh_d;
    end
  end

  assign p_d = (PW'(hh_q) <<< (2 * LoW))
             + ((PW'(lh_q) + PW'(hl_q)) <<< LoW)
             + $signed(PW'(ll_q));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= p_d;
    end
  end

  assign p_o = p_q;

endmodule

// ===== rtl/core/mpra_div_step.sv =====
// One restoring division stage for both quotient components.
// Depends on mpra_pkg (ctl_t, QUOT_BITS).
module mpra_div_step #(
  parameter int MagW  = 92,
  parameter int Shift = 30
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    en_i,
  input  mpra_pkg::ctl_t                          ctl_i,
  input  logic [MagW-1:0]                         den_i,
  input  logic [MagW+mpra_pkg::QUOT_BITS-1:0]     rre_i,
  input  logic [MagW+mpra_pkg::QUOT_BITS-1:0]     rim_i,
  input  logic [mpra_pkg::QUOT_BITS-1:0]          qre_i,
  input  logic [mpra_pkg::QUOT_BITS-1:0]          qim_i,
  output mpra_pkg::ctl_t                          ctl_o,
  output logic [MagW-1:0]                         den_o,
  output logic [MagW+mpra_pkg::QUOT_BITS-1:0]     rre_o,
  output logic [MagW+mpra_pkg::QUOT_BITS-1:0]     rim_o,
  output logic [mpra_pkg::QUOT_BITS-1:0]          qre_o,
  output logic [mpra_pkg::QUOT_BITS-1:0]          qim_o
);

  localparam int DW = MagW + mpra_pkg::QUOT_BITS;
  localparam int QB = mpra_pkg::QUOT_BITS;

  logic [DW-1:0] dsh;
  logic          ge_re, ge_im;
  logic [DW-1:0] rre_d, rim_d, rre_q, rim_q;
  logic [QB-1:0] qre_d, qim_d, qre_q, qim_q;
  logic [MagW-1:0] den_q;
  mpra_pkg::ctl_t  ctl_q;

  assign dsh   = DW'(den_i) << Shift;
  assign ge_re = rre_i >= dsh;
  assign ge_im = rim_i >= dsh;
  assign rre_d = ge_re ? rre_i - dsh : rre_i;
  assign rim_d = ge_im ? rim_i - dsh : rim_i;
  assign qre_d = qre_i | (QB'(ge_re) << Shift);
  assign qim_d = qim_i | (QB'(ge_im) << Shift);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den_q <= den_i;
      rre_q <= rre_d;
      rim_q <= rim_d;
      qre_q <= qre_d;
      qim_q <= qim_d;
    end
  end

  assign ctl_o = ctl_q;
  assign den_o = den_q;
  assign rre_o = rre_q;
  assign rim_o = rim_q;
  assign qre_o = qre_q;
  assign qim_o = qim_q;

endmodule

// ===== rtl/core/mpra_mod_step.sv =====
// Remainder stage: folds two dividend bits per lane into the running remainder.
// Depends on mpra_pkg (ctl_t, rem_step).
module mpra_mod_step #(
  parameter int TopBit = 31
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  mpra_pkg::ctl_t                    ctl_i,
  input  logic [mpra_pkg::MOD_W-1:0]        mw_i,
  input  logic [mpra_pkg::MOD_W-1:0]        mh_i,
  input  logic [mpra_pkg::VAL_W-1:0]        ax_i,
  input  logic [mpra_pkg::VAL_W-1:0]        ay_i,
  input  logic [mpra_pkg::ADDR_W-1:0]       rx_i,
  input  logic [mpra_pkg::ADDR_W-1:0]       ry_i,
  output mpra_pkg::ctl_t                    ctl_o,
  output logic [mpra_pkg::VAL_W-1:0]        ax_o,
  output logic [mpra_pkg::VAL_W-1:0]        ay_o,
  output logic [mpra_pkg::ADDR_W-1:0]       rx_o,
  output logic [mpra_pkg::ADDR_W-1:0]       ry_o
);

  logic [mpra_pkg::ADDR_W-1:0] rx_d, ry_d, rx_q, ry_q;
  logic [mpra_pkg::VAL_W-1:0]  ax_q, ay_q;
  mpra_pkg::ctl_t              ctl_q;

  always_comb begin
    rx_d = rx_i;
    ry_d = ry_i;
    for (int k = 0; k < mpra_pkg::STEP_BITS; k++) begin
      rx_d = mpra_pkg::rem_step(rx_d, ax_i[TopBit-k], mw_i);
      ry_d = mpra_pkg::rem_step(ry_d, ay_i[TopBit-k], mh_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ax_q <= ax_i;
      ay_q <= ay_i;
      rx_q <= rx_d;
      ry_q <= ry_d;
    end
  end

  assign ctl_o = ctl_q;
  assign ax_o  = ax_q;
  assign ay_o  = ay_q;
  assign rx_o  = rx_q;
  assign ry_o  = ry_q;

endmodule

// ===== rtl/core/mobius_pixel_remap_address_unit.sv =====
// Channel  | direction | payload
// s_axis   | in        | tdata: out_col, out_row (signed, COORD_BITS each)
// m_axis   | out       | tdata: src_x, src_y; tuser: status
// cfg      | in        | cfg_index_i selects coef_a..d, frame_width, frame_height
//
// One pixel per cycle sustained while no result is held at m_axis. Depth is set by the
// 31 restoring quotient stages and the 16 two-bit remainder stages.
// Reset clears all valid bits and loads default coefficients (the map 1/z).
// The whole pipe advances together; a held result at m_axis freezes it.
// Top level of the Mobius remap address unit.
// Depends on mpra_pkg, mpra_front, mpra_wmul, mpra_div_step, mpra_mod_step.
`include "mobius_pixel_remap_address_unit_assert.svh"

module mobius_pixel_remap_address_unit #(
  parameter int FRAC_BITS  = 24,
  parameter int COORD_BITS = 12
) (
  input  logic clk_i,
  input  logic rst_ni,
  // stream in
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [((2*COORD_BITS+7)/8)*8-1:0]     s_axis_tdata,  // out_col, out_row
  // stream out
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [23:0]                           m_axis_tdata,  // src_x, src_y
  output logic [1:0]                            m_axis_tuser,  // status
  // configuration writes
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [mpra_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [63:0]                           cfg_data_i
);

  localparam int CW    = mpra_pkg::COEF_W;
  localparam int EW    = CW + COORD_BITS + 2;   // numerator / denominator parts
  localparam int PW    = 2 * EW + 1;            // products summed
  localparam int MW    = 2 * EW;                // magnitudes
  localparam int DW    = MW + mpra_pkg::QUOT_BITS;
  localparam int QB    = mpra_pkg::QUOT_BITS;
  localparam int NMOD  = mpra_pkg::VAL_W / mpra_pkg::STEP_BITS;
  localparam int AW    = mpra_pkg::ADDR_W;
  localparam logic [63:0] ONE_HIGH = 64'(1) << (32 + FRAC_BITS);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [63:0] coef_a_q, coef_b_q, coef_c_q, coef_d_q;
  logic [mpra_pkg::MOD_W-1:0] frame_w_q, frame_h_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_a_q  <= ONE_HIGH;
      coef_b_q  <= '0;
      coef_c_q  <= '0;
      coef_d_q  <= ONE_HIGH;
      frame_w_q <= 13'd1280;
      frame_h_q <= 13'd720;
    end else if (cfg_valid_i) begin
      unique case (mpra_pkg::cfg_idx_e'(cfg_index_i))
        mpra_pkg::CFG_COEF_A:  coef_a_q  <= cfg_data_i;
        mpra_pkg::CFG_COEF_B:  coef_b_q  <= cfg_data_i;
        mpra_pkg::CFG_COEF_C:  coef_c_q  <= cfg_data_i;
        mpra_pkg::CFG_COEF_D:  coef_d_q  <= cfg_data_i;
        mpra_pkg::CFG_FRAME_W: frame_w_q <= cfg_data_i[mpra_pkg::MOD_W-1:0];
        mpra_pkg::CFG_FRAME_H: frame_h_q <= cfg_data_i[mpra_pkg::MOD_W-1:0];
        default: ;
      endcase
    end
  end

  // moduli clamped to [1, 4096]
  logic [mpra_pkg::MOD_W-1:0] mod_w, mod_h;
  assign mod_w = (frame_w_q == '0) ? mpra_pkg::MOD_MIN :
                 (frame_w_q > mpra_pkg::MOD_MAX) ? mpra_pkg::MOD_MAX : frame_w_q;
  assign mod_h = (frame_h_q == '0) ? mpra_pkg::MOD_MIN :
                 (frame_h_q > mpra_pkg::MOD_MAX) ? mpra_pkg::MOD_MAX : frame_h_q;

  // ---------------------------------------------------------------------------
  // Global advance: the pipe moves unless a finished result is held
  // ---------------------------------------------------------------------------
  logic out_valid_q;
  logic en;
  assign en            = !out_valid_q || m_axis_tready;
  assign s_axis_tready = en;

  // ---------------------------------------------------------------------------
  // Stages 1-2: linear terms
  // ---------------------------------------------------------------------------
  logic signed [COORD_BITS-1:0] zr, zi;
  logic signed [EW-1:0] nr, ni, er, ei;

  assign zr = s_axis_tdata[COORD_BITS-1:0];
  assign zi = s_axis_tdata[2*COORD_BITS-1:COORD_BITS];

  mpra_front #(.CoordW(COORD_BITS)) u_front (
    .clk_i (clk_i),
    .en_i  (en),
    .zr_i  (zr),
    .zi_i  (zi),
    .ar_i  (coef_a_q[63:32]),
    .ai_i  (coef_a_q[31:0]),
    .br_i  (coef_b_q[63:32]),
    .bi_i  (coef_b_q[31:0]),
    .cr_i  (coef_c_q[63:32]),
    .ci_i  (coef_c_q[31:0]),
    .dr_i  (coef_d_q[63:32]),
    .di_i  (coef_d_q[31:0]),
    .nr_o  (nr),
    .ni_o  (ni),
    .er_o  (er),
    .ei_o  (ei)
  );

  logic v1_q, v2_q, v3_q, v4_q;
  logic dz3_q, dz4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      v4_q  <= 1'b0;
      dz3_q <= 1'b0;
      dz4_q <= 1'b0;
    end else if (en) begin
      v1_q  <= s_axis_tvalid;
      v2_q  <= v1_q;
      v3_q  <= v2_q;
      v4_q  <= v3_q;
      dz3_q <= (er == '0) && (ei == '0);
      dz4_q <= dz3_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stages 3-4: N*conj(D) and |D|^2 products
  // ---------------------------------------------------------------------------
  logic signed [2*EW-1:0] p_ee, p_ii, p_ne, p_ie, p_ier, p_nei;

  mpra_wmul #(.W(EW)) u_mul_ee  (.clk_i(clk_i), .en_i(en), .a_i(er), .b_i(er), .p_o(p_ee));
  mpra_wmul #(.W(EW)) u_mul_ii  (.clk_i(clk_i), .en_i(en), .a_i(ei), .b_i(ei), .p_o(p_ii));
  mpra_wmul #(.W(EW)) u_mul_ne  (.clk_i(clk_i), .en_i(en), .a_i(nr), .b_i(er), .p_o(p_ne));
  mpra_wmul #(.W(EW)) u_mul_ie  (.clk_i(clk_i), .en_i(en), .a_i(ni), .b_i(ei), .p_o(p_ie));
  mpra_wmul #(.W(EW)) u_mul_ier (.clk_i(clk_i), .en_i(en), .a_i(ni), .b_i(er), .p_o(p_ier));
  mpra_wmul #(.W(EW)) u_mul_nei (.clk_i(clk_i), .en_i(en), .a_i(nr), .b_i(ei), .p_o(p_nei));

  // ---------------------------------------------------------------------------
  // Stage 5: sums, stage 6: magnitudes, stage 7: saturation check
  // ---------------------------------------------------------------------------
  mpra_pkg::ctl_t ctl5_q, ctl6_q, ctl7_q;
  logic signed [PW-1:0] den5_q, pre5_q, pim5_q;
  logic [MW-1:0] den6_q, mre6_q, mim6_q, den7_q;
  logic [DW-1:0] rre7_q, rim7_q;
  logic [DW-1:0] den6_sh;

  assign den6_sh = DW'(den6_q) << QB;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl5_q <= '0;
      ctl6_q <= '0;
      ctl7_q <= '0;
    end else if (en) begin
      ctl5_q          <= '0;
      ctl5_q.valid    <= v4_q;
      ctl5_q.den_zero <= dz4_q;
      ctl6_q          <= ctl5_q;
      ctl6_q.neg_re   <= pre5_q[PW-1];
      ctl6_q.neg_im   <= pim5_q[PW-1];
      ctl7_q          <= ctl6_q;
      ctl7_q.sat_re   <= DW'(mre6_q) >= den6_sh;
      ctl7_q.sat_im   <= DW'(mim6_q) >= den6_sh;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      den5_q <= PW'(p_ee) + PW'(p_ii);
      pre5_q <= PW'(p_ne) + PW'(p_ie);
      pim5_q <= PW'(p_ier) - PW'(p_nei);
      den6_q <= den5_q[MW-1:0];
      mre6_q <= pre5_q[PW-1] ? MW'(-pre5_q) : pre5_q[MW-1:0];
      mim6_q <= pim5_q[PW-1] ? MW'(-pim5_q) : pim5_q[MW-1:0];
      den7_q <= den6_q;
      rre7_q <= DW'(mre6_q);
      rim7_q <= DW'(mim6_q);
    end
  end

  // ---------------------------------------------------------------------------
  // Stages 8-38: restoring division, one quotient bit per stage
  // ---------------------------------------------------------------------------
  mpra_pkg::ctl_t div_ctl [QB+1];
  logic [MW-1:0]  div_den [QB+1];
  logic [DW-1:0]  div_rre [QB+1];
  logic [DW-1:0]  div_rim [QB+1];
  logic [QB-1:0]  div_qre [QB+1];
  logic [QB-1:0]  div_qim [QB+1];

  assign div_ctl[0] = ctl7_q;
  assign div_den[0] = den7_q;
  assign div_rre[0] = rre7_q;
  assign div_rim[0] = rim7_q;
  assign div_qre[0] = '0;
  assign div_qim[0] = '0;

  for (genvar i = 0; i < QB; i++) begin : g_div
    mpra_div_step #(.MagW(MW), .Shift(QB - 1 - i)) u_step (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .ctl_i  (div_ctl[i]),
      .den_i  (div_den[i]),
      .rre_i  (div_rre[i]),
      .rim_i  (div_rim[i]),
      .qre_i  (div_qre[i]),
      .qim_i  (div_qim[i]),
      .ctl_o  (div_ctl[i+1]),
      .den_o  (div_den[i+1]),
      .rre_o  (div_rre[i+1]),
      .rim_o  (div_rim[i+1]),
      .qre_o  (div_qre[i+1]),
      .qim_o  (div_qim[i+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Stage 39: signed, saturated quotient plus offset; stage 40: magnitude
  // ---------------------------------------------------------------------------
  mpra_pkg::ctl_t c1_ctl_q, c2_ctl_q;
  logic [QB-1:0] m_re, m_im;
  logic [mpra_pkg::SUM_W-1:0] s_re_q, s_im_q;
  logic [mpra_pkg::VAL_W-1:0] a_x_q, a_y_q;

  assign m_re = div_ctl[QB].sat_re ? mpra_pkg::QUOT_MAX : div_qre[QB];
  assign m_im = div_ctl[QB].sat_im ? mpra_pkg::QUOT_MAX : div_qim[QB];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_ctl_q <= '0;
      c2_ctl_q <= '0;
    end else if (en) begin
      c1_ctl_q        <= div_ctl[QB];
      c2_ctl_q        <= c1_ctl_q;
      // from here on neg_* is the sign of the offset sum
      c2_ctl_q.neg_re <= s_re_q[mpra_pkg::SUM_W-1];
      c2_ctl_q.neg_im <= s_im_q[mpra_pkg::SUM_W-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s_re_q <= div_ctl[QB].neg_re ? mpra_pkg::ADDR_OFFSET - mpra_pkg::SUM_W'(m_re)
                                   : mpra_pkg::ADDR_OFFSET + mpra_pkg::SUM_W'(m_re);
      s_im_q <= div_ctl[QB].neg_im ? mpra_pkg::ADDR_OFFSET - mpra_pkg::SUM_W'(m_im)
                                   : mpra_pkg::ADDR_OFFSET + mpra_pkg::SUM_W'(m_im);
      a_x_q  <= s_re_q[mpra_pkg::SUM_W-1] ? mpra_pkg::VAL_W'(-s_re_q)
                                          : s_re_q[mpra_pkg::VAL_W-1:0];
      a_y_q  <= s_im_q[mpra_pkg::SUM_W-1] ? mpra_pkg::VAL_W'(-s_im_q)
                                          : s_im_q[mpra_pkg::VAL_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Stages 41-56: remainder of |sum|, two bits per stage
  // ---------------------------------------------------------------------------
  mpra_pkg::ctl_t             mod_ctl [NMOD+1];
  logic [mpra_pkg::VAL_W-1:0] mod_ax  [NMOD+1];
  logic [mpra_pkg::VAL_W-1:0] mod_ay  [NMOD+1];
  logic [AW-1:0]              mod_rx  [NMOD+1];
  logic [AW-1:0]              mod_ry  [NMOD+1];

  assign mod_ctl[0] = c2_ctl_q;
  assign mod_ax[0]  = a_x_q;
  assign mod_ay[0]  = a_y_q;
  assign mod_rx[0]  = '0;
  assign mod_ry[0]  = '0;

  for (genvar k = 0; k < NMOD; k++) begin : g_mod
    mpra_mod_step #(.TopBit(mpra_pkg::VAL_W - 1 - mpra_pkg::STEP_BITS * k)) u_step (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .ctl_i  (mod_ctl[k]),
      .mw_i   (mod_w),
      .mh_i   (mod_h),
      .ax_i   (mod_ax[k]),
      .ay_i   (mod_ay[k]),
      .rx_i   (mod_rx[k]),
      .ry_i   (mod_ry[k]),
      .ctl_o  (mod_ctl[k+1]),
      .ax_o   (mod_ax[k+1]),
      .ay_o   (mod_ay[k+1]),
      .rx_o   (mod_rx[k+1]),
      .ry_o   (mod_ry[k+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Stage 57: floor correction and output register
  // ---------------------------------------------------------------------------
  mpra_pkg::ctl_t  fin;
  logic [AW-1:0]   rx_f, ry_f, src_x_d, src_y_d, src_x_q, src_y_q;
  mpra_pkg::status_e status_d, status_q;

  assign fin  = mod_ctl[NMOD];
  assign rx_f = mod_rx[NMOD];
  assign ry_f = mod_ry[NMOD];

  always_comb begin
    src_x_d  = (fin.neg_re && rx_f != '0) ? AW'(mod_w - mpra_pkg::MOD_W'(rx_f)) : rx_f;
    src_y_d  = (fin.neg_im && ry_f != '0) ? AW'(mod_h - mpra_pkg::MOD_W'(ry_f)) : ry_f;
    status_d = (fin.sat_re || fin.sat_im) ? mpra_pkg::STATUS_SAT : mpra_pkg::STATUS_OK;
    if (fin.den_zero) begin
      src_x_d  = '0;
      src_y_d  = '0;
      status_d = mpra_pkg::STATUS_DEN_ZERO;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= fin.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      src_x_q  <= src_x_d;
      src_y_q  <= src_y_d;
      status_q <= status_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {src_y_q, src_x_q};
  assign m_axis_tuser  = status_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  logic out_den_zero;
  assign out_den_zero = (status_q == mpra_pkg::STATUS_DEN_ZERO);

  `MPRA_ASSERT_CLK(a_denzero_addr, (m_axis_tvalid && out_den_zero) |-> (m_axis_tdata == '0))
  `MPRA_ASSERT_CLK(a_src_x_range, m_axis_tvalid |-> (mpra_pkg::MOD_W'(src_x_q) < mod_w))
  `MPRA_ASSERT_CLK(a_src_y_range, m_axis_tvalid |-> (mpra_pkg::MOD_W'(src_y_q) < mod_h))
  // an edge seen in reset leaves the pipe empty at the following edge
  `MPRA_ASSERT_RST(a_reset_idle, (!rst_ni) |=> (!m_axis_tvalid && !v1_q))

endmodule

// ===== bench/mobius_pixel_remap_address_unit_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the Mobius remap address unit: directed table, then random pixels.
// Depends on mpra_pkg and mobius_pixel_remap_address_unit.

module mobius_pixel_remap_address_unit_tb;

  localparam int LATENCY   = 57;
  localparam longint LIMIT = 400000;
  localparam longint ONE   = 64'd1 << 56;  // 1.0 in the real half

  typedef struct {
    logic [11:0]       src_x;
    logic [11:0]       src_y;
    mpra_pkg::status_e status;
  } addr_t;

  // one row of the directed table; has_exp marks rows with a typed-in result
  typedef struct {
    logic [11:0] col;
    logic [11:0] row;
    bit          has_exp;
    addr_t       exp;
  } pix_row_t;

  logic clk_i, rst_ni;
  logic s_axis_tvalid, s_axis_tready;
  logic [23:0] s_axis_tdata;  // out_col [11:0], out_row [23:12]
  logic m_axis_tvalid, m_axis_tready;
  logic [23:0] m_axis_tdata;  // src_x [11:0], src_y [23:12]
  logic [1:0] m_axis_tuser;   // status
  logic cfg_valid_i, cfg_ready_o;
  logic [mpra_pkg::CFG_IDX_W-1:0] cfg_index_i;
  logic [63:0] cfg_data_i;

  mobius_pixel_remap_address_unit dut (.*);

  // bench copy of the register file
  logic [63:0] coef_a_q, coef_b_q, coef_c_q, coef_d_q;
  logic [12:0] width_q, height_q;

  addr_t  pending_addrs[$];
  int     errors;
  longint cycles;
  int     send_idle_pct, recv_stall_pct;
  bit     hold_off_req;
  int     hold_off_left;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("mobius_pixel_remap_address_unit regression: fail");
      $finish;
    end
  end

  function automatic longint half_of(logic [63:0] r, bit hi);
    return hi ? longint'($signed(r[63:32])) : longint'($signed(r[31:0]));
  endfunction

  // truncated, saturated quotient of signed 128-bit p by positive d
  function automatic longint div_sat(logic signed [127:0] p, logic signed [127:0] d,
                                     inout bit sat);
    logic [127:0] mag, q;
    mag = p < 0 ? -p : p;
    q = mag / d;
    if (q > 128'h7FFF_FFFF) begin
      q = 128'h7FFF_FFFF;
      sat = 1;
    end
    return p < 0 ? -longint'(q[31:0]) : longint'(q[31:0]);
  endfunction

  function automatic logic [11:0] wrap_addr(longint q, logic [12:0] m);
    longint s, mm, r;
    mm = m == 0 ? 1 : (m > 4096 ? 4096 : m);
    s = q + 1000000;
    r = s % mm;
    if (r < 0) r += mm;
    return r[11:0];
  endfunction

  function automatic addr_t remap(logic [11:0] col, logic [11:0] row);
    longint zr, zi, nr, ni, er, ei;
    logic signed [127:0] den, pre, pim;
    bit sat;
    addr_t a;
    zr = longint'($signed(col));
    zi = longint'($signed(row));
    nr = half_of(coef_a_q, 1) - (half_of(coef_b_q, 1) * zr - half_of(coef_b_q, 0) * zi);
    ni = half_of(coef_a_q, 0) - (half_of(coef_b_q, 1) * zi + half_of(coef_b_q, 0) * zr);
    er = half_of(coef_c_q, 1) + (half_of(coef_d_q, 1) * zr - half_of(coef_d_q, 0) * zi);
    ei = half_of(coef_c_q, 0) + (half_of(coef_d_q, 1) * zi + half_of(coef_d_q, 0) * zr);
    if (er == 0 && ei == 0) begin
      a.src_x = '0; a.src_y = '0; a.status = mpra_pkg::STATUS_DEN_ZERO;
      return a;
    end
    den = 128'(er) * 128'(er) + 128'(ei) * 128'(ei);
    pre = 128'(nr) * 128'(er) + 128'(ni) * 128'(ei);
    pim = 128'(ni) * 128'(er) - 128'(nr) * 128'(ei);
    sat = 0;
    a.src_x = wrap_addr(div_sat(pre, den, sat), width_q);
    a.src_y = wrap_addr(div_sat(pim, den, sat), height_q);
    a.status = sat ? mpra_pkg::STATUS_SAT : mpra_pkg::STATUS_OK;
    return a;
  endfunction

  // result checker and receiver-side stall
  always @(posedge clk_i) begin
    addr_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_addrs.size() == 0) begin
        $error("unexpected result transaction %h/%h", m_axis_tdata, m_axis_tuser);
        errors++;
      end else begin
        e = pending_addrs.pop_front();
        if (m_axis_tdata[11:0] !== e.src_x) begin
          $error("src_x exp %0d got %0d", e.src_x, m_axis_tdata[11:0]); errors++;
        end
        if (m_axis_tdata[23:12] !== e.src_y) begin
          $error("src_y exp %0d got %0d", e.src_y, m_axis_tdata[23:12]); errors++;
        end
        if (m_axis_tuser !== e.status) begin
          $error("status exp %0d got %0d", e.status, m_axis_tuser); errors++;
        end
      end
    end
    m_axis_tready <= (hold_off_left > 1) ? 1'b0 : ($urandom_range(99) >= recv_stall_pct);
  end

  // long receiver hold-off, counted in cycles
  always @(posedge clk_i) begin
    if (hold_off_req && hold_off_left == 0) hold_off_left <= 600;
    else if (hold_off_left > 0) hold_off_left <= hold_off_left - 1;
  end

  task automatic write_reg(mpra_pkg::cfg_idx_e idx, logic [63:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      mpra_pkg::CFG_COEF_A:  coef_a_q = val;
      mpra_pkg::CFG_COEF_B:  coef_b_q = val;
      mpra_pkg::CFG_COEF_C:  coef_c_q = val;
      mpra_pkg::CFG_COEF_D:  coef_d_q = val;
      mpra_pkg::CFG_FRAME_W: width_q  = val[12:0];
      mpra_pkg::CFG_FRAME_H: height_q = val[12:0];
      default: ;
    endcase
  endtask

  // push one pixel; expectation is queued at the accepting edge
  task automatic send_pixel(logic [11:0] col, logic [11:0] row, bit has_exp, addr_t exp);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {row, col};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_addrs.push_back(has_exp ? exp : remap(col, row));
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    while (pending_addrs.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 8) @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand_coef();
    logic [31:0] re, im;
    // mostly modest coefficients, sometimes full-range bits
    case ($urandom_range(3))
      0: begin re = $urandom; im = $urandom; end
      1: begin re = 32'($signed($urandom_range(512)) - 256) << 20; im = '0; end
      default: begin
        re = 32'($signed($urandom_range(8192)) - 4096) << 14;
        im = 32'($signed($urandom_range(8192)) - 4096) << 14;
      end
    endcase
    return {re, im};
  endfunction

  function automatic addr_t mk(int x, int y, mpra_pkg::status_e s);
    addr_t a;
    a.src_x = 12'(x); a.src_y = 12'(y); a.status = s;
    return a;
  endfunction

  initial begin
    pix_row_t dir_rows[$];
    addr_t none;
    int phase;
    errors = 0; cycles = 0; hold_off_req = 0; hold_off_left = 0;
    send_idle_pct = 0; recv_stall_pct = 0;
    rst_ni = 1'b0; s_axis_tvalid = 1'b0; s_axis_tdata = '0; m_axis_tready = 1'b0;
    cfg_valid_i = 1'b0; cfg_index_i = mpra_pkg::CFG_COEF_A; cfg_data_i = '0;
    coef_a_q = ONE; coef_b_q = '0; coef_c_q = '0; coef_d_q = ONE;
    width_q = 13'd1280; height_q = 13'd720;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset map is t = 1/z; origin gives a zero denominator
    dir_rows.push_back('{12'd0, 12'd0, 1, mk(0, 0, mpra_pkg::STATUS_DEN_ZERO)});
    // z = 1: t = 1 -> 1000001 mod 1280 = 321, 1000000 mod 720 = 640
    dir_rows.push_back('{12'd1, 12'd0, 1, mk(321, 640, mpra_pkg::STATUS_OK)});
    dir_rows.push_back('{12'h7FF, 12'h7FF, 0, none});
    dir_rows.push_back('{12'h800, 12'h800, 0, none});
    dir_rows.push_back('{12'h800, 12'h7FF, 0, none});
    dir_rows.push_back('{12'hFFF, 12'h001, 0, none});
    dir_rows.push_back('{12'h000, 12'hFFF, 0, none});
    foreach (dir_rows[i])
      send_pixel(dir_rows[i].col, dir_rows[i].row, dir_rows[i].has_exp, dir_rows[i].exp);
    drain();

    // saturation: a huge numerator over a tiny denominator, minimum modulus
    write_reg(mpra_pkg::CFG_COEF_A, {32'h7FFF_FFFF, 32'h8000_0000});
    write_reg(mpra_pkg::CFG_COEF_B, 64'd0);
    write_reg(mpra_pkg::CFG_COEF_C, 64'd1);
    write_reg(mpra_pkg::CFG_COEF_D, 64'd0);
    write_reg(mpra_pkg::CFG_FRAME_W, 64'd1);
    write_reg(mpra_pkg::CFG_FRAME_H, 64'd0);
    send_pixel(12'd5, 12'd9, 1, mk(0, 0, mpra_pkg::STATUS_SAT));
    drain();
    // widest modulus, and an oversize one treated as 4096
    write_reg(mpra_pkg::CFG_FRAME_W, 64'd4096);
    write_reg(mpra_pkg::CFG_FRAME_H, 64'h1FFF);
    write_reg(mpra_pkg::CFG_COEF_C, {32'd1 << 24, 32'd0});
    write_reg(mpra_pkg::CFG_COEF_B, {32'hFF00_0000, 32'd0});  // b = -1, t = a + z
    send_pixel(12'h800, 12'h7FF, 0, none);
    send_pixel(12'h7FF, 12'h800, 0, none);
    drain();

    for (phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
        default: begin send_idle_pct = 38; recv_stall_pct = 38; end
      endcase
      write_reg(mpra_pkg::CFG_COEF_A, rand_coef());
      write_reg(mpra_pkg::CFG_COEF_B, rand_coef());
      write_reg(mpra_pkg::CFG_COEF_C, rand_coef());
      write_reg(mpra_pkg::CFG_COEF_D, rand_coef());
      write_reg(mpra_pkg::CFG_FRAME_W, 64'($urandom_range(4096, 1)));
      write_reg(mpra_pkg::CFG_FRAME_H, 64'($urandom_range(4096, 1)));
      hold_off_req = (phase == 0);
      repeat (62) send_pixel(12'($urandom), 12'($urandom), 0, none);
      hold_off_req = 0;
      drain();
    end

    if (errors == 0) $display("mobius_pixel_remap_address_unit regression: pass");
    else $display("mobius_pixel_remap_address_unit regression: fail");
    $finish;
  end
endmodule
